[sv/particle_pool_engine_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the particle pool engine.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_POOL_ENGINE_TOP_MACROS_SVH
`define PARTICLE_POOL_ENGINE_TOP_MACROS_SVH

// Concurrent check on the rising clock edge, off while reset is held.
`define PPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent check that also holds while reset is held.
`define PPE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[sv/ppe_pkg.sv]
// ----------------------------------------------------------------------------
// ppe_pkg
// Types, codes and helpers shared by the particle pool engine modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ppe_pkg;

  localparam int unsigned POOL_DEPTH_DEF = 2048;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [11:0]        COUNT_LIMIT_RST = 12'd2000;
  localparam logic signed [15:0] GRAVITY_RST     = 16'sd2509;
  localparam logic [15:0]        BASE_SIZE_RST   = 16'd1024;
  localparam logic [8:0]         FALLOFF_RST     = 9'd154;

  localparam logic [23:0] AGE_MAX       = 24'hFFFFFF;
  localparam logic [15:0] RADIUS_FLOOR  = 16'd51;
  localparam logic [7:0]  ALPHA_FULL    = 8'd255;
  localparam int          GRAVITY_SCALE = 20;
  localparam int          ROUND_HALF    = 32768;

  localparam int unsigned DIV_Q_W   = 16;
  localparam int unsigned DIV_NUM_W = 48;
  localparam int unsigned DIV_DEN_W = 32;

  typedef enum logic [1:0] {
    OP_SPAWN = 2'd0,
    OP_TICK  = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    REG_COUNT_LIMIT = 3'd0,
    REG_GRAVITY     = 3'd1,
    REG_BASE_SIZE   = 3'd2,
    REG_FALLOFF     = 3'd3,
    REG_SPAWN_POS_X = 3'd4,
    REG_SPAWN_POS_Y = 3'd5
  } reg_idx_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_SPAWN,
    S_TDV1, S_TDV2, S_TRD, S_TEVAL, S_TMOVE, S_TMUL, S_TWB,
    S_RRD, S_RDATA, S_R1, S_R2, S_R3, S_DIVA, S_DIVR,
    S_OUT
  } ppe_state_e;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [23:0]        age;
    logic [23:0]        life;
  } ppe_entry_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [16:0] spawn_vel_x;
    logic signed [16:0] spawn_vel_y;
    logic [23:0]        spawn_life;
    logic [15:0]        step_time;
    logic [10:0]        read_index;
  } ppe_in_t;

  typedef struct packed {
    logic               accepted;
    logic [11:0]        live_count;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic [15:0]        out_radius;
    logic [7:0]         out_alpha;
  } ppe_res_t;

  typedef struct packed {
    logic capture;
    logic spawn;
    logic dv1;
    logic dv2;
    logic trd;
    logic teval;
    logic tmove;
    logic tmul;
    logic twb;
    logic rrd;
    logic rdata;
    logic r1;
    logic r2;
    logic r3;
    logic div_start;
    logic div_sel_r;
    logic latch_alpha;
    logic latch_radius;
    logic load_out;
  } ppe_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       spawn_ok;
    logic       read_ok;
    logic       tick_more;
    logic       expired;
    logic       div_done;
    logic       out_free;
  } ppe_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -35'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Q.24 to Q.8 with round half up: floor((x + 2^15) / 2^16).
  function automatic logic signed [33:0] round_q24(input logic signed [49:0] x);
    logic signed [49:0] y;
    y = x + 50'(ROUND_HALF);
    return y[49:16];
  endfunction

endpackage

`default_nettype wire

[sv/ppe_in_if.sv]
// ----------------------------------------------------------------------------
// ppe_in_if
// Request channel into the particle pool engine.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppe_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [16:0] spawn_vel_x;
  logic signed [16:0] spawn_vel_y;
  logic [23:0]        spawn_life;
  logic [15:0]        step_time;
  logic [10:0]        read_index;

  modport source (output valid, operation, spawn_vel_x, spawn_vel_y, spawn_life,
                  step_time, read_index, input ready);
  modport sink (input valid, operation, spawn_vel_x, spawn_vel_y, spawn_life,
                step_time, read_index, output ready);
endinterface

`default_nettype wire

[sv/ppe_out_if.sv]
// ----------------------------------------------------------------------------
// ppe_out_if
// Result channel out of the particle pool engine.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppe_out_if;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [11:0]        live_count;
  logic signed [31:0] out_pos_x;
  logic signed [31:0] out_pos_y;
  logic [15:0]        out_radius;
  logic [7:0]         out_alpha;

  modport source (output valid, accepted, live_count, out_pos_x, out_pos_y,
                  out_radius, out_alpha, input ready);
  modport sink (input valid, accepted, live_count, out_pos_x, out_pos_y,
                out_radius, out_alpha, output ready);
endinterface

`default_nettype wire

[sv/ppe_cfg_if.sv]
// ----------------------------------------------------------------------------
// ppe_cfg_if
// Register write channel of the particle pool engine.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppe_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_index;
  logic [15:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

[sv/ppe_div.sv]
// ----------------------------------------------------------------------------
// ppe_div
// Restoring divider, one quotient bit per cycle, 16-bit quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module ppe_div (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start_i,
  input  wire  [ppe_pkg::DIV_NUM_W-1:0]  num_i,
  input  wire  [ppe_pkg::DIV_DEN_W-1:0]  den_i,
  output logic                           done_o,
  output logic [ppe_pkg::DIV_Q_W-1:0]    quot_o
);
  import ppe_pkg::*;

  localparam int unsigned DW = DIV_DEN_W + DIV_Q_W - 1;
  localparam int unsigned CNT_W = $clog2(DIV_Q_W + 1);

  logic [DIV_NUM_W-1:0] rem_q;
  logic [DW-1:0]        d_q;
  logic [DIV_Q_W-1:0]   q_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 busy_q, done_q;
  logic                 ge;

  // The caller guarantees the quotient fits in DIV_Q_W bits.
  assign ge = DIV_NUM_W'(d_q) <= rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_Q_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      d_q   <= {den_i, (DIV_Q_W-1)'(0)};
      q_q   <= '0;
    end else if (busy_q) begin
      if (ge) rem_q <= rem_q - DIV_NUM_W'(d_q);
      q_q <= {q_q[DIV_Q_W-2:0], ge};
      d_q <= d_q >> 1;
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

`default_nettype wire

[sv/ppe_ctrl.sv]
// ----------------------------------------------------------------------------
// ppe_ctrl
// Sequencer for spawn, tick and read requests of the particle pool engine.
// ----------------------------------------------------------------------------
`default_nettype none

`include "particle_pool_engine_top_macros.svh"

module ppe_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  ppe_pkg::ppe_status_t status_i,
  output ppe_pkg::ppe_cmd_t    cmd_o
);
  import ppe_pkg::*;

  ppe_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status_i.op)
          OP_SPAWN: state_d = S_SPAWN;
          OP_TICK:  state_d = S_TDV1;
          OP_READ:  state_d = status_i.read_ok ? S_RRD : S_OUT;
          default:  state_d = S_OUT;
        endcase
      end
      S_SPAWN: begin
        cmd_o.spawn = 1'b1;
        state_d = S_OUT;
      end
      S_TDV1: begin
        cmd_o.dv1 = 1'b1;
        state_d = S_TDV2;
      end
      S_TDV2: begin
        cmd_o.dv2 = 1'b1;
        state_d = S_TRD;
      end
      S_TRD: begin
        if (status_i.tick_more) begin
          cmd_o.trd = 1'b1;
          state_d = S_TEVAL;
        end else begin
          state_d = S_OUT;
        end
      end
      S_TEVAL: begin
        cmd_o.teval = 1'b1;
        state_d = status_i.expired ? S_TMOVE : S_TMUL;
      end
      S_TMOVE: begin
        // The tail entry now fills the freed slot, which is checked again.
        cmd_o.tmove = 1'b1;
        state_d = S_TRD;
      end
      S_TMUL: begin
        cmd_o.tmul = 1'b1;
        state_d = S_TWB;
      end
      S_TWB: begin
        cmd_o.twb = 1'b1;
        state_d = S_TRD;
      end
      S_RRD: begin
        cmd_o.rrd = 1'b1;
        state_d = S_RDATA;
      end
      S_RDATA: begin
        cmd_o.rdata = 1'b1;
        state_d = S_R1;
      end
      S_R1: begin
        cmd_o.r1 = 1'b1;
        state_d = S_R2;
      end
      S_R2: begin
        cmd_o.r2 = 1'b1;
        state_d = S_R3;
      end
      S_R3: begin
        cmd_o.r3 = 1'b1;
        cmd_o.div_start = 1'b1;
        state_d = S_DIVA;
      end
      S_DIVA: begin
        if (status_i.div_done) begin
          cmd_o.latch_alpha = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel_r = 1'b1;
          state_d = S_DIVR;
        end
      end
      S_DIVR: begin
        if (status_i.div_done) begin
          cmd_o.latch_radius = 1'b1;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  `PPE_ASSERT(a_tick_ends, (state_q == S_TRD && !status_i.tick_more) |=> (state_q == S_OUT), "tick did not finish after last particle")
  `PPE_ASSERT(a_div_chain, (state_q == S_DIVA && status_i.div_done) |=> (state_q == S_DIVR), "radius divide did not follow alpha divide")
  `PPE_ASSERT_ALWAYS(a_ready_idle, in_ready_o |-> (state_q == S_IDLE || !rst_ni), "request taken outside idle")

endmodule

`default_nettype wire

[sv/ppe_dp.sv]
// ----------------------------------------------------------------------------
// ppe_dp
// Particle store, register file, arithmetic and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "particle_pool_engine_top_macros.svh"

module ppe_dp #(
  parameter int unsigned POOL_DEPTH = ppe_pkg::POOL_DEPTH_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  ppe_pkg::ppe_in_t                 in_i,
  input  wire                              cfg_valid_i,
  input  wire  [ppe_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire  [ppe_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  ppe_pkg::ppe_cmd_t                cmd_i,
  output ppe_pkg::ppe_status_t             status_o,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output ppe_pkg::ppe_res_t                out_o
);
  import ppe_pkg::*;

  localparam int unsigned AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned CW = $clog2(POOL_DEPTH + 1);

  // Configuration registers.
  logic [11:0]        count_limit_q;
  logic signed [15:0] gravity_q;
  logic [15:0]        base_q;
  logic [8:0]         falloff_q;
  logic [12:0]        spx_q, spy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_limit_q <= COUNT_LIMIT_RST;
      gravity_q     <= GRAVITY_RST;
      base_q        <= BASE_SIZE_RST;
      falloff_q     <= FALLOFF_RST;
      spx_q         <= '0;
      spy_q         <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_COUNT_LIMIT: count_limit_q <= cfg_data_i[11:0];
        REG_GRAVITY:     gravity_q     <= cfg_data_i;
        REG_BASE_SIZE:   base_q        <= cfg_data_i;
        REG_FALLOFF:     falloff_q     <= cfg_data_i[8:0];
        REG_SPAWN_POS_X: spx_q         <= cfg_data_i[12:0];
        REG_SPAWN_POS_Y: spy_q         <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // Control state: live count, tick cursor, result register handshake.
  logic [CW-1:0] live_q, i_q, live_m1;
  logic [16:0]   live_w;
  logic          out_valid_q;

  assign live_w  = 17'(live_q);
  assign live_m1 = live_q - 1'b1;

  // Request fields and working registers.
  ppe_in_t            in_q;
  ppe_entry_t         mem [POOL_DEPTH];
  ppe_entry_t         rdata_q, wdata;
  logic [AW-1:0]      raddr, waddr;
  logic               re, we;
  logic [15:0]        idx_w;
  logic signed [32:0] gdt_q;
  logic signed [37:0] g20;
  logic signed [33:0] dv_q;
  logic [23:0]        age_sum_lo;
  logic [24:0]        age_sum;
  logic [23:0]        age_new, age_new_q;
  logic signed [31:0] vy_new, vy_new_q;
  logic signed [48:0] pxp_q, pyp_q;
  logic signed [31:0] px_new, py_new;
  logic [23:0]        life_q, used_q;
  logic [32:0]        fu_q;
  logic [31:0]        an_q;
  logic signed [34:0] x_q;
  logic               rad_pos_q;
  logic [47:0]        num_q;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done;
  logic [DIV_Q_W-1:0]   div_quot;
  logic                 res_acc_q;
  logic signed [31:0]   res_px_q, res_py_q;
  logic [15:0]          res_rad_q;
  logic [7:0]           res_alpha_q;
  ppe_res_t             out_q;

  assign idx_w      = 16'(in_q.read_index);
  assign age_sum    = {1'b0, rdata_q.age} + 25'(in_q.step_time);
  assign age_sum_lo = age_sum[23:0];
  assign age_new    = age_sum[24] ? AGE_MAX : age_sum_lo;
  assign vy_new     = sat32({{3{rdata_q.vy[31]}}, rdata_q.vy} + 35'(dv_q));
  assign g20        = 38'(gdt_q) * 38'(GRAVITY_SCALE);
  assign px_new     = sat32({{3{rdata_q.px[31]}}, rdata_q.px} + 35'(round_q24(50'(pxp_q))));
  assign py_new     = sat32({{3{rdata_q.py[31]}}, rdata_q.py} + 35'(round_q24(50'(pyp_q))));

  assign status_o.op        = in_q.operation;
  assign status_o.spawn_ok  = (live_w < 17'(count_limit_q)) && (live_w < 17'(POOL_DEPTH));
  assign status_o.read_ok   = 17'(in_q.read_index) < live_w;
  assign status_o.tick_more = i_q < live_q;
  assign status_o.expired   = age_new >= rdata_q.life;
  assign status_o.div_done  = div_done;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // Store port selection.
  always_comb begin
    re    = cmd_i.trd || cmd_i.rrd || (cmd_i.teval && status_o.expired);
    raddr = i_q[AW-1:0];
    if (cmd_i.rrd) raddr = idx_w[AW-1:0];
    else if (cmd_i.teval) raddr = live_m1[AW-1:0];
    we    = (cmd_i.spawn && status_o.spawn_ok) || cmd_i.tmove || cmd_i.twb;
    waddr = cmd_i.spawn ? live_q[AW-1:0] : i_q[AW-1:0];
    wdata = rdata_q;
    if (cmd_i.spawn) begin
      wdata.px   = 32'({spx_q, 8'h00});
      wdata.py   = 32'({spy_q, 8'h00});
      wdata.vx   = 32'(in_q.spawn_vel_x);
      wdata.vy   = 32'(in_q.spawn_vel_y);
      wdata.age  = '0;
      wdata.life = in_q.spawn_life;
    end else if (cmd_i.twb) begin
      wdata.px  = px_new;
      wdata.py  = py_new;
      wdata.vy  = vy_new_q;
      wdata.age = age_new_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q      <= '0;
      i_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.spawn && status_o.spawn_ok) live_q <= live_q + 1'b1;
      if (cmd_i.teval && status_o.expired) live_q <= live_m1;
      if (cmd_i.dv1) i_q <= '0;
      if (cmd_i.twb) i_q <= i_q + 1'b1;
      if (cmd_i.load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q        <= in_i;
      res_acc_q   <= 1'b0;
      res_px_q    <= '0;
      res_py_q    <= '0;
      res_rad_q   <= '0;
      res_alpha_q <= '0;
    end
    if (cmd_i.spawn) res_acc_q <= status_o.spawn_ok;
    if (cmd_i.dv1) gdt_q <= gravity_q * $signed({1'b0, in_q.step_time});
    if (cmd_i.dv2) dv_q <= round_q24(50'(g20));
    if (cmd_i.teval) begin
      age_new_q <= age_new;
      vy_new_q  <= vy_new;
    end
    if (cmd_i.tmul) begin
      pxp_q <= rdata_q.vx * $signed({1'b0, in_q.step_time});
      pyp_q <= vy_new_q * $signed({1'b0, in_q.step_time});
    end
    if (cmd_i.rdata) begin
      res_acc_q <= 1'b1;
      res_px_q  <= rdata_q.px;
      res_py_q  <= rdata_q.py;
      // A zero lifetime reads as fully expired.
      if (rdata_q.life == '0) begin
        life_q <= 24'd1;
        used_q <= 24'd1;
      end else begin
        life_q <= rdata_q.life;
        used_q <= (rdata_q.age > rdata_q.life) ? rdata_q.life : rdata_q.age;
      end
    end
    if (cmd_i.r1) begin
      fu_q <= 33'(falloff_q) * 33'(used_q);
      an_q <= 32'(ALPHA_FULL) * 32'(life_q - used_q);
    end
    if (cmd_i.r2) x_q <= $signed({3'b000, life_q, 8'h00}) - $signed({2'b00, fu_q});
    if (cmd_i.r3) begin
      // A positive numerator term never exceeds 256 times the lifetime.
      num_q     <= 48'(base_q) * 48'(x_q[31:0]);
      rad_pos_q <= !x_q[34] && (x_q != '0) && (base_q != '0);
    end
    if (cmd_i.latch_alpha) res_alpha_q <= div_quot[7:0];
    if (cmd_i.latch_radius) begin
      res_rad_q <= (!rad_pos_q || div_quot < RADIUS_FLOOR) ? RADIUS_FLOOR : div_quot;
    end
    if (cmd_i.load_out) begin
      out_q.accepted   <= res_acc_q;
      out_q.live_count <= 12'(live_q);
      out_q.out_pos_x  <= res_px_q;
      out_q.out_pos_y  <= res_py_q;
      out_q.out_radius <= res_rad_q;
      out_q.out_alpha  <= res_alpha_q;
    end
  end

  assign div_num = cmd_i.div_sel_r ? num_q : DIV_NUM_W'(an_q);
  assign div_den = cmd_i.div_sel_r ? {life_q, 8'h00} : DIV_DEN_W'(life_q);

  ppe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `PPE_ASSERT(a_live_bound, live_w <= 17'(POOL_DEPTH), "live count above pool depth")
  `PPE_ASSERT(a_spawn_inc, (cmd_i.spawn && status_o.spawn_ok) |=> (live_q == CW'($past(live_q) + 1'b1)), "spawn did not grow the pool")
  `PPE_ASSERT(a_expire_dec, (cmd_i.teval && status_o.expired) |=> (live_q == CW'($past(live_q) - 1'b1)), "expiry did not shrink the pool")

endmodule

`default_nettype wire

[sv/particle_pool_engine_top.sv]
// ----------------------------------------------------------------------------
// particle_pool_engine_top
// Compact particle pool with spawn, tick and read requests.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request (spawn, tick or read) with valid/ready; out_ch
//   returns one result for every request; cfg_ch writes the six registers
//   and is always ready. Write registers only while no request is in flight.
// Steps, from acceptance to the result register:
//   a spawn passes decode and the spawn step; unused codes and an
//   out-of-range read go straight from decode; a live read fetches the
//   entry and runs the alpha divide, then the radius divide. A tick reads
//   each particle and writes survivors back; the tail refills expired slots.
// One request is worked on at a time; the next is taken once the result
// register is loaded, even while that result still waits on out_ch.
// A stalled receiver holds the result and, once a second result is done,
// holds the block as well.
// Reset empties the pool and loads the register defaults; the store itself
// is not cleared, since only spawned slots are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_pool_engine_top #(
  parameter int unsigned POOL_DEPTH = ppe_pkg::POOL_DEPTH_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  ppe_in_if.sink      in_ch,
  ppe_out_if.source   out_ch,
  ppe_cfg_if.sink     cfg_ch
);
  import ppe_pkg::*;

  ppe_in_t     in_req;
  ppe_res_t    res;
  ppe_cmd_t    cmd;
  ppe_status_t status;
  logic        in_ready;

  assign in_req.operation   = in_ch.operation;
  assign in_req.spawn_vel_x = in_ch.spawn_vel_x;
  assign in_req.spawn_vel_y = in_ch.spawn_vel_y;
  assign in_req.spawn_life  = in_ch.spawn_life;
  assign in_req.step_time   = in_ch.step_time;
  assign in_req.read_index  = in_ch.read_index;
  assign in_ch.ready        = in_ready;
  assign cfg_ch.ready       = 1'b1;

  ppe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ppe_dp #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_req),
    .cfg_valid_i (cfg_ch.valid),
    .cfg_index_i (cfg_ch.reg_index),
    .cfg_data_i  (cfg_ch.wdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_o       (res)
  );

  assign out_ch.accepted   = res.accepted;
  assign out_ch.live_count = res.live_count;
  assign out_ch.out_pos_x  = res.out_pos_x;
  assign out_ch.out_pos_y  = res.out_pos_y;
  assign out_ch.out_radius = res.out_radius;
  assign out_ch.out_alpha  = res.out_alpha;

endmodule

`default_nettype wire
